FILE: hw/rtl/vdt_pkg.sv
// vdt_pkg: shared constants and types for the vertex welding table with ray picking
// no dependencies
`timescale 1ns / 1ps
package vdt_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrWidth  = $clog2(TableDepth);
  localparam int CountWidth = AddrWidth + 1;
  localparam int CoordWidth = 25;
  localparam int DirWidth   = 16;
  localparam int IndexWidth = 10;
  localparam int DistWidth  = 64;
  localparam int TolWidth   = 16;
  localparam int RadWidth   = 24;

  localparam logic [1:0] OP_FIND  = 2'd0;
  localparam logic [1:0] OP_PICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic REG_TOL    = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [AddrWidth-1:0] idx;
  } tag_t;
endpackage

FILE: hw/rtl/vdt_if.sv
// vdt_in_if / vdt_out_if: valid-ready channels for items and results
// depends on vdt_pkg
`timescale 1ns / 1ps
interface vdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [vdt_pkg::CoordWidth-1:0] pos_x;
  logic signed [vdt_pkg::CoordWidth-1:0] pos_y;
  logic signed [vdt_pkg::CoordWidth-1:0] pos_z;
  logic signed [vdt_pkg::DirWidth-1:0]   dir_x;
  logic signed [vdt_pkg::DirWidth-1:0]   dir_y;
  logic signed [vdt_pkg::DirWidth-1:0]   dir_z;
  modport source (output valid, operation, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface vdt_out_if;
  logic        valid;
  logic        ready;
  logic [vdt_pkg::IndexWidth-1:0] result_index;
  logic        was_present;
  logic        hit;
  logic        table_full;
  logic [vdt_pkg::CountWidth-1:0] point_count;
  modport source (output valid, result_index, was_present, hit, table_full, point_count,
                  input ready);
  modport sink (input valid, result_index, was_present, hit, table_full, point_count,
                output ready);
endinterface

FILE: hw/rtl/vdt_dist_pipe.sv
// vdt_dist_pipe: seven-stage squared ray-to-point distance pipeline
// depends on vdt_pkg
`timescale 1ns / 1ps
module vdt_dist_pipe (
  input  logic clk,
  input  logic rst,
  input  vdt_pkg::tag_t tag_in,
  input  logic [3*vdt_pkg::CoordWidth-1:0] point,
  input  logic signed [vdt_pkg::CoordWidth-1:0] org [3],
  input  logic signed [vdt_pkg::DirWidth-1:0]   dir [3],
  output vdt_pkg::tag_t tag_out,
  output logic [vdt_pkg::DistWidth-1:0] sq_len,
  output logic busy
);
  localparam int TW = vdt_pkg::CoordWidth + 1;
  localparam int PW = TW + vdt_pkg::DirWidth;
  localparam int SW = PW + 2;
  localparam int S8W = SW - 14;
  localparam int SDW = S8W + vdt_pkg::DirWidth;
  localparam int QW = SDW + 2;
  localparam int MW = QW - 14;
  localparam int AW = 31;

  vdt_pkg::tag_t tag [1:7];
  logic signed [TW-1:0]  t1 [3], t2 [3], t3 [3], t4 [3];
  logic signed [PW-1:0]  p2 [3];
  logic signed [S8W-1:0] s8;
  logic signed [SDW-1:0] sd4 [3];
  logic [AW-1:0]         a5 [3];
  logic [2*AW-1:0]       sq6 [3];
  logic signed [SW-1:0]  s_sum;
  logic signed [QW-1:0]  qw [3];
  logic signed [MW-1:0]  q [3];
  logic [MW-1:0]         qm [3];

  always_comb begin
    s_sum = SW'(p2[0]) + SW'(p2[1]) + SW'(p2[2]) + SW'(8192);
    for (int k = 0; k < 3; k++) begin
      qw[k] = {{(QW-TW-14){t4[k][TW-1]}}, t4[k], 14'b0} - QW'(sd4[k]) + QW'(8192);
      q[k]  = qw[k][QW-1:14];
      qm[k] = q[k][MW-1] ? MW'(-q[k]) : MW'(q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 7; i++) tag[i].valid <= 1'b0;
    end else begin
      tag[1].valid <= tag_in.valid;
      for (int i = 2; i <= 7; i++) tag[i].valid <= tag[i-1].valid;
    end
    tag[1].idx <= tag_in.idx;
    for (int i = 2; i <= 7; i++) tag[i].idx <= tag[i-1].idx;
    for (int k = 0; k < 3; k++) begin
      t1[k]  <= TW'($signed(point[k*vdt_pkg::CoordWidth +: vdt_pkg::CoordWidth]))
                - TW'(org[k]);
      t2[k]  <= t1[k];
      p2[k]  <= PW'(t1[k]) * PW'(dir[k]);
      t3[k]  <= t2[k];
      t4[k]  <= t3[k];
      sd4[k] <= SDW'(s8) * SDW'(dir[k]);
      a5[k]  <= (qm[k] > MW'(1 << 30)) ? AW'(1 << 30) : qm[k][AW-1:0];
      sq6[k] <= (2*AW)'(a5[k]) * (2*AW)'(a5[k]);
    end
    s8     <= s_sum[SW-1:14];
    sq_len <= vdt_pkg::DistWidth'(sq6[0]) + vdt_pkg::DistWidth'(sq6[1])
              + vdt_pkg::DistWidth'(sq6[2]);
  end

  assign tag_out = tag[7];
  assign busy = tag[1].valid | tag[2].valid | tag[3].valid | tag[4].valid
              | tag[5].valid | tag[6].valid | tag[7].valid;
endmodule

FILE: hw/rtl/vertex_dedup_table_ray_pick.sv
// vertex_dedup_table_ray_pick: point table with find-or-insert and ray picking
// depends on vdt_pkg, vdt_if, vdt_dist_pipe
//
//   port     dir  handshake        carries
//   in_ch    in   valid/ready      operation, pos_x/y/z, dir_x/y/z
//   out_ch   out  valid/ready      result_index, was_present, hit, table_full, point_count
//   cfg_*    in   cfg_we only      0 match_tolerance, 1 pick_radius
//
// find and pick read every stored entry once from the point memory, one a cycle,
// then drain the distance pipeline
// clear and unused codes go straight to the finish step; one item is in work at a time
// reset empties the table at once, memory contents are not cleared
// a finished result waits in the output register; the next item is taken meanwhile,
// and its finish step waits until the held result is taken
`timescale 1ns / 1ps
module vertex_dedup_table_ray_pick (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [vdt_pkg::RadWidth-1:0] cfg_data,
  vdt_in_if.sink   in_ch,
  vdt_out_if.source out_ch
);
  localparam int CW = vdt_pkg::CoordWidth;
  localparam int AW = vdt_pkg::AddrWidth;
  localparam int NW = vdt_pkg::CountWidth;
  localparam int DTW = CW + 1;
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_FINISH = 2'd2;

  logic [1:0] state;
  logic [vdt_pkg::TolWidth-1:0] tol;
  logic [vdt_pkg::RadWidth-1:0] radius;
  logic [2*vdt_pkg::RadWidth-1:0] rad_sq;
  logic [NW-1:0] count, issue_cnt;
  logic [1:0] op;
  logic signed [CW-1:0] org [3];
  logic signed [vdt_pkg::DirWidth-1:0] dir [3];

  logic [3*CW-1:0] mem [vdt_pkg::TableDepth];
  logic [3*CW-1:0] rd_data;
  vdt_pkg::tag_t rd_tag, m_tag, d_tag;
  logic m_hit, found, hit;
  logic [AW-1:0] fidx, pidx;
  logic [vdt_pkg::DistWidth-1:0] best, sq_len;
  logic busy, issuing, mem_we;
  logic signed [DTW-1:0] diff [3];
  logic [DTW-1:0] dmag [3];

  logic out_valid, was_present, table_full, hit_q;
  logic [vdt_pkg::IndexWidth-1:0] result_index;
  logic [NW-1:0] point_count;

  assign in_ch.ready = (state == S_IDLE);
  assign issuing = (state == S_SCAN) && (issue_cnt < count);
  assign mem_we = (state == S_FINISH) && (!out_valid || out_ch.ready) && (op == vdt_pkg::OP_FIND)
                  && !found && (count < NW'(vdt_pkg::TableDepth));
  assign rad_sq = radius * radius;

  always_ff @(posedge clk) begin
    if (issuing) rd_data <= mem[issue_cnt[AW-1:0]];
    if (mem_we) mem[count[AW-1:0]] <= {org[2], org[1], org[0]};
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = DTW'($signed(rd_data[k*CW +: CW])) - DTW'(org[k]);
      dmag[k] = diff[k][DTW-1] ? DTW'(-diff[k]) : DTW'(diff[k]);
    end
  end

  vdt_dist_pipe u_dist (
    .clk(clk), .rst(rst), .tag_in(rd_tag), .point(rd_data), .org(org), .dir(dir),
    .tag_out(d_tag), .sq_len(sq_len), .busy(busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tol <= vdt_pkg::TolWidth'(26);
      radius <= vdt_pkg::RadWidth'(2048);
      count <= '0;
      rd_tag.valid <= 1'b0;
      m_tag.valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == vdt_pkg::REG_TOL) tol <= cfg_data[vdt_pkg::TolWidth-1:0];
        else radius <= cfg_data;
      end
      if (out_valid && out_ch.ready && state != S_FINISH) out_valid <= 1'b0;
      rd_tag.valid <= issuing;
      m_tag.valid <= rd_tag.valid;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op <= in_ch.operation;
            org[0] <= in_ch.pos_x; org[1] <= in_ch.pos_y; org[2] <= in_ch.pos_z;
            dir[0] <= in_ch.dir_x; dir[1] <= in_ch.dir_y; dir[2] <= in_ch.dir_z;
            issue_cnt <= '0;
            found <= 1'b0;
            hit <= 1'b0;
            best <= vdt_pkg::DistWidth'(rad_sq);
            state <= (in_ch.operation == vdt_pkg::OP_FIND ||
                      in_ch.operation == vdt_pkg::OP_PICK) ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          if (issuing) issue_cnt <= issue_cnt + NW'(1);
          if (m_tag.valid && m_hit && !found) begin
            found <= 1'b1;
            fidx <= m_tag.idx;
          end
          if (d_tag.valid && sq_len < best) begin
            best <= sq_len;
            pidx <= d_tag.idx;
            hit <= 1'b1;
          end
          if (!issuing && !rd_tag.valid && !m_tag.valid && !busy) state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            case (op)
              vdt_pkg::OP_FIND: begin
                was_present <= found;
                hit_q <= 1'b0;
                table_full <= !found && !mem_we;
                result_index <= found ? vdt_pkg::IndexWidth'(fidx)
                              : (mem_we ? vdt_pkg::IndexWidth'(count) : '0);
                point_count <= mem_we ? count + NW'(1) : count;
                if (mem_we) count <= count + NW'(1);
              end
              vdt_pkg::OP_PICK: begin
                was_present <= 1'b0;
                hit_q <= hit;
                table_full <= 1'b0;
                result_index <= hit ? vdt_pkg::IndexWidth'(pidx) : '0;
                point_count <= count;
              end
              vdt_pkg::OP_CLEAR: begin
                was_present <= 1'b0;
                hit_q <= 1'b0;
                table_full <= 1'b0;
                result_index <= '0;
                count <= '0;
                point_count <= '0;
              end
              default: begin
                was_present <= 1'b0;
                hit_q <= 1'b0;
                table_full <= 1'b0;
                result_index <= '0;
                point_count <= count;
              end
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    rd_tag.idx <= issue_cnt[AW-1:0];
    m_tag.idx <= rd_tag.idx;
    m_hit <= (dmag[0] <= DTW'(tol)) && (dmag[1] <= DTW'(tol)) && (dmag[2] <= DTW'(tol));
  end

  assign out_ch.valid = out_valid;
  assign out_ch.result_index = result_index;
  assign out_ch.was_present = was_present;
  assign out_ch.hit = hit_q;
  assign out_ch.table_full = table_full;
  assign out_ch.point_count = point_count;
endmodule

FILE: hw/rtl/vdt_checker.sv
// vdt_checker: port-level assertions, bound to vertex_dedup_table_ray_pick
// depends on vdt_pkg
`timescale 1ns / 1ps
module vdt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [vdt_pkg::IndexWidth-1:0] result_index,
  input logic was_present,
  input logic hit,
  input logic table_full,
  input logic [vdt_pkg::CountWidth-1:0] point_count
);
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !(in_valid && in_ready))
    else $error("two items accepted back to back");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_index) && $stable(point_count))
    else $error("stalled result changed");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> point_count <= vdt_pkg::CountWidth'(vdt_pkg::TableDepth))
    else $error("point count beyond depth");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !was_present && !table_full)
    else $error("pick and find flags together");
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |->
      point_count == vdt_pkg::CountWidth'(vdt_pkg::TableDepth) && result_index == '0)
    else $error("full flag with room left");
endmodule

bind vertex_dedup_table_ray_pick vdt_checker u_vdt_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_index(out_ch.result_index), .was_present(out_ch.was_present),
  .hit(out_ch.hit), .table_full(out_ch.table_full), .point_count(out_ch.point_count)
);

FILE: sim/vertex_dedup_table_ray_pick_tb.sv
// vertex_dedup_table_ray_pick_tb: point table find-or-insert, ray pick and clear,
// checked against a behavioral predictor with random idling on both channels
// depends on vdt_pkg, vdt_if and the vertex_dedup_table_ray_pick rtl
`timescale 1ns / 1ps
module vertex_dedup_table_ray_pick_tb;

  typedef struct packed {
    logic [1:0] op;
    logic signed [vdt_pkg::CoordWidth-1:0] px, py, pz;
    logic signed [vdt_pkg::DirWidth-1:0] dx, dy, dz;
  } query_t;

  typedef struct packed {
    logic [vdt_pkg::IndexWidth-1:0] index;
    logic present;
    logic hit;
    logic full;
    logic [vdt_pkg::CountWidth-1:0] count;
  } answer_t;

  typedef struct {
    query_t q;
    logic known;
    answer_t a;
  } row_t;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [vdt_pkg::RadWidth-1:0] cfg_data;

  vdt_in_if in_ch ();
  vdt_out_if out_ch ();

  vertex_dedup_table_ray_pick u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  longint pt_x[vdt_pkg::TableDepth], pt_y[vdt_pkg::TableDepth], pt_z[vdt_pkg::TableDepth];
  int unsigned n_points;
  longint unsigned tolerance, radius;
  answer_t pending[$];
  int errors;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_q14(longint v);
    longint a;
    a = v + 8192;
    return a >>> 14;
  endfunction

  function automatic answer_t weld_or_pick(query_t q);
    answer_t r;
    longint p[3], d[3], t[3], s, s8, qq;
    longint unsigned best, sq_len, m;
    r = '0;
    p[0] = q.px; p[1] = q.py; p[2] = q.pz;
    d[0] = q.dx; d[1] = q.dy; d[2] = q.dz;
    if (q.op == vdt_pkg::OP_FIND) begin
      for (int i = 0; i < n_points; i++) begin
        if (magnitude(p[0] - pt_x[i]) <= tolerance && magnitude(p[1] - pt_y[i]) <= tolerance
            && magnitude(p[2] - pt_z[i]) <= tolerance) begin
          r.present = 1'b1;
          r.index = vdt_pkg::IndexWidth'(i);
          break;
        end
      end
      if (!r.present) begin
        if (n_points < vdt_pkg::TableDepth) begin
          pt_x[n_points] = p[0]; pt_y[n_points] = p[1]; pt_z[n_points] = p[2];
          r.index = vdt_pkg::IndexWidth'(n_points);
          n_points++;
        end else begin
          r.full = 1'b1;
        end
      end
    end else if (q.op == vdt_pkg::OP_PICK) begin
      best = radius * radius;
      for (int i = 0; i < n_points; i++) begin
        t[0] = pt_x[i] - p[0]; t[1] = pt_y[i] - p[1]; t[2] = pt_z[i] - p[2];
        s = t[0] * d[0] + t[1] * d[1] + t[2] * d[2];
        s8 = round_q14(s);
        sq_len = 0;
        for (int k = 0; k < 3; k++) begin
          qq = round_q14(t[k] * 16384 - s8 * d[k]);
          m = magnitude(qq);
          if (m > (64'd1 << 30)) m = 64'd1 << 30;
          sq_len += m * m;
        end
        if (sq_len < best) begin
          best = sq_len;
          r.index = vdt_pkg::IndexWidth'(i);
          r.hit = 1'b1;
        end
      end
    end else if (q.op == vdt_pkg::OP_CLEAR) begin
      n_points = 0;
    end
    r.count = vdt_pkg::CountWidth'(n_points);
    return r;
  endfunction

  // result side: random stalls, compare with oldest expectation
  initial begin
    answer_t got, want;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
      got = '{out_ch.result_index, out_ch.was_present, out_ch.hit, out_ch.table_full,
              out_ch.point_count};
      if (pending.size() == 0) begin
        report("unexpected result", got.index, 0);
      end else begin
        want = pending.pop_front();
        if (got.index != want.index) report("result_index", got.index, want.index);
        if (got.present != want.present) report("was_present", got.present, want.present);
        if (got.hit != want.hit) report("hit", got.hit, want.hit);
        if (got.full != want.full) report("table_full", got.full, want.full);
        if (got.count != want.count) report("point_count", got.count, want.count);
      end
    end
  end

  task automatic send(query_t q, logic known, answer_t a);
    answer_t pred;
    int idle;
    idle = $urandom_range(0, 9);
    if (idle != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.operation, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.dir_x, in_ch.dir_y,
     in_ch.dir_z} <= q;
    @(posedge clk iff in_ch.ready);
    pred = weld_or_pick(q);
    if (known && pred != a) report("table row", pred, a);
    pending.push_back(pred);
  endtask

  task automatic drain_and_set(logic idx, longint unsigned val);
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= vdt_pkg::RadWidth'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == vdt_pkg::REG_TOL) tolerance = val & 16'hFFFF;
    else radius = val & 24'hFFFFFF;
  endtask

  function automatic query_t make_q(logic [1:0] op, longint x, longint y, longint z,
                                    longint a, longint b, longint c);
    query_t q;
    q.op = op;
    q.px = vdt_pkg::CoordWidth'(x);
    q.py = vdt_pkg::CoordWidth'(y);
    q.pz = vdt_pkg::CoordWidth'(z);
    q.dx = vdt_pkg::DirWidth'(a);
    q.dy = vdt_pkg::DirWidth'(b);
    q.dz = vdt_pkg::DirWidth'(c);
    return q;
  endfunction

  function automatic answer_t make_a(int idx, bit pres, bit h, bit f, int cnt);
    answer_t a;
    a.index = vdt_pkg::IndexWidth'(idx);
    a.present = pres; a.hit = h; a.full = f;
    a.count = vdt_pkg::CountWidth'(cnt);
    return a;
  endfunction

  function automatic longint rnd_coord(int mode);
    case (mode)
      0: return $signed($urandom_range(0, 4095)) - 2048;
      1: return $signed($urandom_range(0, 33554431)) - 16777216;
      default: return $urandom_range(0, 1) ? -16777216 : 16777215;
    endcase
  endfunction

  function automatic longint rnd_dir();
    int c;
    c = $urandom_range(0, 7);
    case (c)
      0: return 16384;
      1: return -16384;
      2: return 0;
      3: return -32768;
      4: return 32767;
      default: return $signed($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  initial begin
    row_t dir_rows[$];
    query_t q;
    longint bx, by, bz;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = vdt_pkg::REG_TOL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = vdt_pkg::OP_FIND;
    {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
    errors = 0;
    n_points = 0;
    tolerance = 26;
    radius = 2048;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_rows = '{
      '{make_q(vdt_pkg::OP_PICK, 0, 0, 0, 16384, 0, 0), 1, make_a(0, 0, 0, 0, 0)},
      '{make_q(vdt_pkg::OP_FIND, 0, 0, 0, 0, 0, 0), 1, make_a(0, 0, 0, 0, 1)},
      '{make_q(vdt_pkg::OP_FIND, 26, -26, 26, 0, 0, 0), 1, make_a(0, 1, 0, 0, 1)},
      '{make_q(vdt_pkg::OP_FIND, 27, 0, 0, 0, 0, 0), 1, make_a(1, 0, 0, 0, 2)},
      '{make_q(vdt_pkg::OP_FIND, 16777215, 16777215, 16777215, 0, 0, 0), 1,
        make_a(2, 0, 0, 0, 3)},
      '{make_q(vdt_pkg::OP_FIND, -16777216, -16777216, -16777216, 0, 0, 0), 1,
        make_a(3, 0, 0, 0, 4)},
      '{make_q(vdt_pkg::OP_PICK, 0, 0, -1000, 0, 0, 16384), 0, '0},
      '{make_q(vdt_pkg::OP_PICK, -16777216, 16777215, 0, 16384, 0, 0), 0, '0},
      '{make_q(vdt_pkg::OP_PICK, 0, 2047, 0, 16384, 0, 0), 0, '0},
      '{make_q(vdt_pkg::OP_PICK, 0, 2048, 0, 16384, 0, 0), 0, '0},
      '{make_q(vdt_pkg::OP_PICK, 5, 5, 5, 10000, -10000, 32767), 0, '0},
      '{make_q(vdt_pkg::OP_PICK, 5, 5, 5, -32768, 0, 0), 0, '0},
      '{make_q(vdt_pkg::OP_SPARE, 1, 2, 3, 4, 5, 6), 1, make_a(0, 0, 0, 0, 4)},
      '{make_q(vdt_pkg::OP_CLEAR, 7, 7, 7, 1, 1, 1), 1, make_a(0, 0, 0, 0, 0)},
      '{make_q(vdt_pkg::OP_PICK, 0, 0, 0, 0, 0, 16384), 1, make_a(0, 0, 0, 0, 0)},
      '{make_q(vdt_pkg::OP_FIND, 100, 200, 300, 0, 0, 0), 1, make_a(0, 0, 0, 0, 1)}
    };
    foreach (dir_rows[i]) send(dir_rows[i].q, dir_rows[i].known, dir_rows[i].a);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          drain_and_set(vdt_pkg::REG_TOL, 26);
          drain_and_set(vdt_pkg::REG_RADIUS, 2048);
        end
        1: begin
          drain_and_set(vdt_pkg::REG_TOL, 65535);
          drain_and_set(vdt_pkg::REG_RADIUS, 16777215);
        end
        2: begin
          drain_and_set(vdt_pkg::REG_TOL, 0);
          drain_and_set(vdt_pkg::REG_RADIUS, 0);
        end
        3: begin
          drain_and_set(vdt_pkg::REG_TOL, 300);
          drain_and_set(vdt_pkg::REG_RADIUS, 600);
        end
        default: begin
          drain_and_set(vdt_pkg::REG_TOL, $urandom_range(0, 65535));
          drain_and_set(vdt_pkg::REG_RADIUS, $urandom_range(0, 16777215));
        end
      endcase
      bx = rnd_coord(0); by = rnd_coord(0); bz = rnd_coord(0);
      for (int n = 0; n < 95; n++) begin
        int kind, mode;
        kind = $urandom_range(0, 99);
        mode = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        if (kind < 55) begin
          if (mode == 0)
            q = make_q(vdt_pkg::OP_FIND, bx + $signed($urandom_range(0, 600)) - 300,
                       by + $signed($urandom_range(0, 600)) - 300,
                       bz + $signed($urandom_range(0, 600)) - 300, 0, 0, 0);
          else
            q = make_q(vdt_pkg::OP_FIND, rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                       0, 0, 0);
        end else if (kind < 93) begin
          q = make_q(vdt_pkg::OP_PICK, mode == 0 ? bx + $signed($urandom_range(0, 2000)) - 1000
                     : rnd_coord(mode), mode == 0 ? by : rnd_coord(mode),
                     mode == 0 ? bz : rnd_coord(mode), rnd_dir(), rnd_dir(), rnd_dir());
        end else if (kind < 97) begin
          q = make_q(vdt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
        end else begin
          q = make_q(vdt_pkg::OP_SPARE, rnd_coord(1), rnd_coord(1), rnd_coord(1),
                     rnd_dir(), rnd_dir(), rnd_dir());
        end
        send(q, 0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
